### hw/rtl/kwb_pkg.sv
// shared types and constants for the k-weighting biquad prefilter
// used by kwb_ctrl, kwb_dp and the top level; no dependencies
`default_nettype none

package kwb_pkg;

    localparam int COEF_W              = 32;  // coefficient register width, q4.28
    localparam int ACC_W               = 64;  // accumulator width, wraps like a 64-bit sum
    localparam int NUM_COEF            = 8;
    localparam int COEF_SEL_W          = 3;
    localparam int CFG_IDX_W           = 4;   // one spare bit so out-of-range writes are visible
    localparam int DEF_COEF_FRAC_BITS  = 28;
    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int TAP_CNT_W           = 3;
    localparam int SHELF_TAPS          = 5;
    localparam int HP_TAPS             = 3;

    // coefficient slots, also the register index of the config port
    typedef enum logic [COEF_SEL_W-1:0] {
        TAP_B0  = 3'd0,   // shelf b0
        TAP_B1  = 3'd1,   // shelf b1
        TAP_B2  = 3'd2,   // shelf b2
        TAP_A1  = 3'd3,   // shelf a1
        TAP_A2  = 3'd4,   // shelf a2
        TAP_G   = 3'd5,   // high-pass numerator gain
        TAP_HA1 = 3'd6,   // high-pass a1
        TAP_HA2 = 3'd7    // high-pass a2
    } t_tap;

    typedef logic signed [COEF_W-1:0] t_coef_arr [NUM_COEF];

    localparam t_coef_arr COEF_RESET = '{
        32'sd412081938, -32'sd722546694, 32'sd321691119, -32'sd453832899,
        32'sd196623809, 32'sd267101332, -32'sd534199295, 32'sd265770496
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHELF,
        ST_SHELF_DRAIN,
        ST_SHELF_ROUND,
        ST_DIFF,
        ST_HP,
        ST_HP_DRAIN,
        ST_HP_ROUND
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic take_in;    // capture a new sample, clear accumulator
        logic mac_en;     // issue one product for the selected tap
        t_tap tap;
        logic mid_load;   // round/saturate shelf result, clear accumulator
        logic diff_load;  // form mid - 2*m1 + m2
        logic fin_load;   // round/saturate output, shift histories
    } t_dp_cmd;

endpackage

`default_nettype wire

### hw/rtl/kwb_dp.sv
// datapath: coefficient registers, filter histories and one shared multiply-accumulate
// depends on kwb_pkg
`default_nettype none

module kwb_dp import kwb_pkg::*; #(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_dp_cmd                     i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                        i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [COEF_W-1:0]           i_cfg_data,
    output logic signed [SAMPLE_BITS+3:0]    o_filtered_out
);

    localparam int MID_BITS = SAMPLE_BITS + 4;
    localparam int OPW      = MID_BITS + 2;
    localparam int PW       = COEF_W + OPW;

    localparam logic signed [ACC_W-1:0] ONE  = 1;
    localparam logic signed [ACC_W-1:0] HALF = ONE <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] MAXV = (ONE <<< (MID_BITS - 1)) - ONE;
    localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

    logic signed [COEF_W-1:0]      r_coef [NUM_COEF];
    logic signed [SAMPLE_BITS-1:0] r_x, r_in1, r_in2;
    logic signed [MID_BITS-1:0]    r_mid, r_m1, r_m2, r_y1, r_y2, r_out;
    logic signed [OPW-1:0]         r_diff;
    logic signed [ACC_W-1:0]       r_prod, r_acc;
    logic                          r_prod_sub, r_prod_vld;

    logic signed [COEF_W-1:0]      coef_sel;
    logic signed [OPW-1:0]         op_sel;
    logic                          op_sub;
    logic signed [PW-1:0]          prod_full;
    logic signed [ACC_W-1:0]       rnd, shr;
    logic signed [MID_BITS-1:0]    sat;
    logic signed [OPW-1:0]         n_diff;

    assign coef_sel = r_coef[i_cmd.tap];

    always_comb begin
        op_sub = 1'b0;
        unique case (i_cmd.tap)
            TAP_B0:  op_sel = OPW'(r_x);
            TAP_B1:  op_sel = OPW'(r_in1);
            TAP_B2:  op_sel = OPW'(r_in2);
            TAP_A1: begin
                op_sel = OPW'(r_m1);
                op_sub = 1'b1;
            end
            TAP_A2: begin
                op_sel = OPW'(r_m2);
                op_sub = 1'b1;
            end
            TAP_G:   op_sel = r_diff;
            TAP_HA1: begin
                op_sel = OPW'(r_y1);
                op_sub = 1'b1;
            end
            TAP_HA2: begin
                op_sel = OPW'(r_y2);
                op_sub = 1'b1;
            end
            default: op_sel = '0;
        endcase
    end

    assign prod_full = coef_sel * op_sel;

    // round half up, drop fraction bits, clamp to the q5.23 range
    assign rnd = r_acc + HALF;
    assign shr = rnd >>> COEF_FRAC_BITS;

    always_comb begin
        priority if (shr > MAXV) begin
            sat = MAXV[MID_BITS-1:0];
        end else if (shr < MINV) begin
            sat = MINV[MID_BITS-1:0];
        end else begin
            sat = shr[MID_BITS-1:0];
        end
    end

    assign n_diff = OPW'(r_mid) - (OPW'(r_m1) <<< 1) + OPW'(r_m2);

    // config writes and histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef     <= COEF_RESET;
            r_in1      <= '0;
            r_in2      <= '0;
            r_m1       <= '0;
            r_m2       <= '0;
            r_y1       <= '0;
            r_y2       <= '0;
            r_prod_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_COEF))) begin
                r_coef[i_cfg_index[COEF_SEL_W-1:0]] <= i_cfg_data;
            end
            r_prod_vld <= i_cmd.mac_en;
            if (i_cmd.fin_load) begin
                r_in2 <= r_in1;
                r_in1 <= r_x;
                r_m2  <= r_m1;
                r_m1  <= r_mid;
                r_y2  <= r_y1;
                r_y1  <= sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mac_en) begin
            r_prod     <= ACC_W'(prod_full);
            r_prod_sub <= op_sub;
        end
        if (i_cmd.take_in || i_cmd.mid_load) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? (r_acc - r_prod) : (r_acc + r_prod);
        end
        if (i_cmd.mid_load) begin
            r_mid <= sat;
        end
        if (i_cmd.diff_load) begin
            r_diff <= n_diff;
        end
        if (i_cmd.fin_load) begin
            r_out <= sat;
        end
    end

    assign o_filtered_out = r_out;

endmodule

`default_nettype wire

### hw/rtl/kwb_ctrl.sv
// controller: sequences the shared multiply-accumulate through both biquad stages
// depends on kwb_pkg
`default_nettype none

module kwb_ctrl import kwb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_dp_cmd   o_cmd
);

    t_state               r_state, n_state;
    logic [TAP_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_vld;
    logic                 out_free;

    assign out_free = !r_out_vld || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = ST_SHELF;
                end
            end
            ST_SHELF: begin
                if (r_cnt == TAP_CNT_W'(SHELF_TAPS - 1)) begin
                    n_state = ST_SHELF_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SHELF_DRAIN: n_state = ST_SHELF_ROUND;
            ST_SHELF_ROUND: n_state = ST_DIFF;
            ST_DIFF:        n_state = ST_HP;
            ST_HP: begin
                if (r_cnt == TAP_CNT_W'(HP_TAPS - 1)) begin
                    n_state = ST_HP_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_HP_DRAIN:    n_state = ST_HP_ROUND;
            ST_HP_ROUND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:        n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.take_in = i_valid;
            end
            ST_SHELF: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.tap    = t_tap'(r_cnt);
            end
            ST_SHELF_ROUND: o_cmd.mid_load  = 1'b1;
            ST_DIFF:        o_cmd.diff_load = 1'b1;
            ST_HP: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.tap    = t_tap'(r_cnt + TAP_CNT_W'(TAP_G));
            end
            ST_HP_ROUND:    o_cmd.fin_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.fin_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule

`default_nettype wire

### hw/rtl/k_weighting_biquad_prefilter.sv
// k-weighting prefilter: high-shelf biquad then high-pass biquad, one shared mac
// the single multiplier steps through eight products plus round and diff steps per sample;
// a new sample is taken only in idle, and the final round waits while an output is untaken
// the output register holds a result while the next sample is taken in
// synchronous active-low reset restores the 48 khz coefficients and clears all histories
// depends on kwb_pkg, kwb_ctrl, kwb_dp
`default_nettype none

module k_weighting_biquad_prefilter import kwb_pkg::*; #(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,    // input width, output is 4 bits wider
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS  // fraction bits of the coefficients
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // sample input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // filtered output channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS+3:0]      o_filtered_out,
    // coefficient write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [COEF_W-1:0]             i_cfg_data
);

    t_dp_cmd cmd;

    // coefficient writes are always accepted; in-range ones land in the next cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: shelf taps b0,b1,b2,a1,a2, round, diff, high-pass taps g,a1,a2, round
    kwb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // coefficients, histories, multiplier, 64-bit accumulator, output register
    kwb_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_in    (i_sample_in),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_filtered_out (o_filtered_out)
    );

endmodule

`default_nettype wire
